[rtl/tmab_pkg.sv]
// Shared constants and types for the texel modulate / alpha blend pipeline.
// No dependencies; used by texel_modulate_alpha_blend, its checker and the bench.
package tmab_pkg;

  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;
  localparam int FACTOR_W = 9;
  localparam int DEPTH_W  = 32;
  localparam int TEXEL_W  = 32;
  localparam int RGB_W    = NUM_CHAN * CHAN_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [FACTOR_W-1:0] UNITY_FACTOR = FACTOR_W'(256);
  localparam logic [CHAN_W-1:0]   CHANNEL_MAX  = CHAN_W'(255);

  // Pipeline latency from accepted beat to result strobe.
  localparam int LATENCY = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MUL_RED    = 3'd0,
    REG_MUL_GREEN  = 3'd1,
    REG_MUL_BLUE   = 3'd2,
    REG_MUL_ALPHA  = 3'd3,
    REG_DEPTH_TEST = 3'd4
  } cfg_reg_t;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [NUM_CHAN-1:0] rgb_t;

  // Stage 1: premultiplied texel, modulated alpha, depth decision.
  typedef struct packed {
    logic                valid;
    logic                reject;
    rgb_t                pre;
    logic [FACTOR_W-1:0] mod_alpha;
    rgb_t                dest;
  } st1_t;

  // Stage 2: modulated source and scaled destination per channel.
  typedef struct packed {
    logic valid;
    logic reject;
    rgb_t src;
    rgb_t dst;
    rgb_t dest;
  } st2_t;

  function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] v);
    return (v > UNITY_FACTOR) ? UNITY_FACTOR : v;
  endfunction

endpackage

[rtl/texel_modulate_alpha_blend.sv]
// Texel modulate and premultiplied alpha-over blend, three register stages.
// Depends on tmab_pkg for constants, stage types and the register map.

// One fragment is accepted on every clock (busy is always low) and its result
// appears on out_valid from the third stage register, in order. The three stages
// are the premultiply/alpha multipliers, the modulate/destination-scale
// multipliers, and the add with saturation. There is no back-pressure on the
// result side: out_valid is a one-cycle strobe that the receiver must take.
// Configuration writes are always accepted (cfg_ready is high) and take effect
// on the next cycle; write them only while no fragment is in flight.
module texel_modulate_alpha_blend (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [tmab_pkg::TEXEL_W-1:0]       in_texel_argb,
  input  logic [tmab_pkg::RGB_W-1:0]         in_dest_rgb,
  input  logic signed [tmab_pkg::DEPTH_W-1:0] in_frag_depth,
  input  logic signed [tmab_pkg::DEPTH_W-1:0] in_stored_depth,
  output logic                               out_valid,
  output logic [tmab_pkg::RGB_W-1:0]         out_rgb,
  output logic                               out_written,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tmab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tmab_pkg::FACTOR_W-1:0]      cfg_data
);

  localparam int CW = tmab_pkg::CHAN_W;
  localparam int FW = tmab_pkg::FACTOR_W;
  localparam int NC = tmab_pkg::NUM_CHAN;
  localparam int PW = CW + FW;  // product width

  // Configuration registers.
  logic [FW-1:0] mul_r [NC];
  logic [FW-1:0] mul_alpha_r;
  logic          depth_en_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NC; i++) mul_r[i] <= tmab_pkg::UNITY_FACTOR;
      mul_alpha_r <= tmab_pkg::UNITY_FACTOR;
      depth_en_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tmab_pkg::REG_MUL_RED:    mul_r[0]    <= tmab_pkg::clamp_factor(cfg_data);
        tmab_pkg::REG_MUL_GREEN:  mul_r[1]    <= tmab_pkg::clamp_factor(cfg_data);
        tmab_pkg::REG_MUL_BLUE:   mul_r[2]    <= tmab_pkg::clamp_factor(cfg_data);
        tmab_pkg::REG_MUL_ALPHA:  mul_alpha_r <= tmab_pkg::clamp_factor(cfg_data);
        tmab_pkg::REG_DEPTH_TEST: depth_en_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1: widen alpha, premultiply the channels, modulate alpha, depth test.
  tmab_pkg::st1_t st1_r, st1_nxt;
  logic [CW-1:0] a_in;
  logic [FW-1:0] alpha_w;
  logic [PW-1:0] pre_prod [NC];
  logic [2*FW-1:0] alpha_prod;

  always_comb begin
    a_in    = in_texel_argb[tmab_pkg::TEXEL_W-1 -: CW];
    alpha_w = FW'(a_in) + FW'(a_in[CW-1]);
    st1_nxt.valid  = start && !busy;
    st1_nxt.reject = depth_en_r && (in_frag_depth < in_stored_depth);
    st1_nxt.dest   = in_dest_rgb;
    for (int i = 0; i < NC; i++) begin
      pre_prod[i]    = PW'(in_texel_argb[i*CW +: CW]) * PW'(alpha_w);
      st1_nxt.pre[i] = pre_prod[i][CW +: CW];
    end
    alpha_prod        = (2*FW)'(alpha_w) * (2*FW)'(mul_alpha_r);
    st1_nxt.mod_alpha = alpha_prod[CW +: FW];
  end

  // Stage 2: apply the channel factors and scale the destination.
  tmab_pkg::st2_t st2_r, st2_nxt;
  logic [FW-1:0] inv_alpha;
  logic [PW-1:0] src_prod [NC];
  logic [PW-1:0] dst_prod [NC];

  always_comb begin
    inv_alpha      = tmab_pkg::UNITY_FACTOR - st1_r.mod_alpha;
    st2_nxt.valid  = st1_r.valid;
    st2_nxt.reject = st1_r.reject;
    st2_nxt.dest   = st1_r.dest;
    for (int i = 0; i < NC; i++) begin
      src_prod[i]    = PW'(st1_r.pre[i]) * PW'(mul_r[i]);
      dst_prod[i]    = PW'(st1_r.dest[i]) * PW'(inv_alpha);
      st2_nxt.src[i] = src_prod[i][CW +: CW];
      st2_nxt.dst[i] = dst_prod[i][CW +: CW];
    end
  end

  // Stage 3: add, saturate, or pass the destination through on reject.
  logic                          out_valid_r, out_valid_nxt;
  logic [tmab_pkg::RGB_W-1:0]    out_rgb_r, out_rgb_nxt;
  logic                          out_written_r, out_written_nxt;
  logic [CW:0]                   sum [NC];

  always_comb begin
    out_valid_nxt   = st2_r.valid;
    out_written_nxt = !st2_r.reject;
    for (int i = 0; i < NC; i++) begin
      sum[i] = (CW+1)'(st2_r.src[i]) + (CW+1)'(st2_r.dst[i]);
      if (st2_r.reject) begin
        out_rgb_nxt[i*CW +: CW] = st2_r.dest[i];
      end else if (sum[i][CW]) begin
        out_rgb_nxt[i*CW +: CW] = tmab_pkg::CHANNEL_MAX;
      end else begin
        out_rgb_nxt[i*CW +: CW] = sum[i][CW-1:0];
      end
    end
  end

  // Payload moves unconditionally; only valid bits need reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_r.valid <= 1'b0;
      st2_r.valid <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st1_r.valid <= st1_nxt.valid;
      st2_r.valid <= st2_nxt.valid;
      out_valid_r <= out_valid_nxt;
    end
    st1_r.reject    <= st1_nxt.reject;
    st1_r.pre       <= st1_nxt.pre;
    st1_r.mod_alpha <= st1_nxt.mod_alpha;
    st1_r.dest      <= st1_nxt.dest;
    st2_r.reject    <= st2_nxt.reject;
    st2_r.src       <= st2_nxt.src;
    st2_r.dst       <= st2_nxt.dst;
    st2_r.dest      <= st2_nxt.dest;
    out_rgb_r       <= out_rgb_nxt;
    out_written_r   <= out_written_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_rgb     = out_rgb_r;
  assign out_written = out_written_r;

endmodule

[rtl/tmab_checker.sv]
// Port-level assertions for texel_modulate_alpha_blend, attached by bind.
// Depends on tmab_pkg for widths and the pipeline latency.
module tmab_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [tmab_pkg::TEXEL_W-1:0]        in_texel_argb,
  input logic [tmab_pkg::RGB_W-1:0]          in_dest_rgb,
  input logic signed [tmab_pkg::DEPTH_W-1:0] in_frag_depth,
  input logic signed [tmab_pkg::DEPTH_W-1:0] in_stored_depth,
  input logic                                out_valid,
  input logic [tmab_pkg::RGB_W-1:0]          out_rgb,
  input logic                                out_written
);

  // Every accepted beat produces a result strobe after passing the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(tmab_pkg::LATENCY) out_valid)
    else $error("result strobe missing after accepted beat");

  // A rejected fragment returns the destination unchanged.
  a_reject_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_written) |-> (out_rgb == $past(in_dest_rgb, tmab_pkg::LATENCY)))
    else $error("rejected fragment altered the destination");

  // Rejection only happens for a strictly lower fragment depth.
  a_reject_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_written) |->
      ($signed($past(in_frag_depth, tmab_pkg::LATENCY)) <
       $signed($past(in_stored_depth, tmab_pkg::LATENCY))))
    else $error("fragment rejected without failing the depth test");

  // A fully transparent texel leaves the destination as it was.
  a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_written &&
     ($past(in_texel_argb[tmab_pkg::TEXEL_W-1 -: tmab_pkg::CHAN_W],
            tmab_pkg::LATENCY) == '0)) |->
      (out_rgb == $past(in_dest_rgb, tmab_pkg::LATENCY)))
    else $error("transparent texel changed the destination");

endmodule

bind texel_modulate_alpha_blend tmab_checker u_tmab_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_texel_argb   (in_texel_argb),
  .in_dest_rgb     (in_dest_rgb),
  .in_frag_depth   (in_frag_depth),
  .in_stored_depth (in_stored_depth),
  .out_valid       (out_valid),
  .out_rgb         (out_rgb),
  .out_written     (out_written)
);

[bench/tb_texel_modulate_alpha_blend.sv]
// Self-checking bench for texel_modulate_alpha_blend: premultiply, modulate, blend, depth test.
// Predicts every pixel from the stimulus and compares it with the result strobe.
// Depends on tmab_pkg and the texel_modulate_alpha_blend RTL only.
module tb_texel_modulate_alpha_blend;
  import tmab_pkg::*;

  localparam int CYCLE_LIMIT    = 60000;
  localparam int LAST_CFG_INDEX = (1 << CFG_IDX_W) - 1;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_BEATS    = 194;
  localparam int IDLE_PERCENT   = 19;
  localparam int STEADY_FIRST   = 700;
  localparam int STEADY_LAST    = 1000;

  typedef struct packed {
    logic [TEXEL_W-1:0]        texel;
    logic [RGB_W-1:0]          dest;
    logic signed [DEPTH_W-1:0] frag;
    logic signed [DEPTH_W-1:0] stored;
  } fragment_t;

  typedef struct packed {
    logic [RGB_W-1:0] rgb;
    logic             written;
  } pixel_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [TEXEL_W-1:0]          in_texel_argb = '0;
  logic [RGB_W-1:0]            in_dest_rgb = '0;
  logic signed [DEPTH_W-1:0]   in_frag_depth = '0;
  logic signed [DEPTH_W-1:0]   in_stored_depth = '0;
  logic                        out_valid;
  logic [RGB_W-1:0]            out_rgb;
  logic                        out_written;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [FACTOR_W-1:0]         cfg_data = '0;

  // Register shadow as the block should see it after each write.
  int unsigned fac_red   = 32'(UNITY_FACTOR);
  int unsigned fac_green = 32'(UNITY_FACTOR);
  int unsigned fac_blue  = 32'(UNITY_FACTOR);
  int unsigned fac_alpha = 32'(UNITY_FACTOR);
  bit          depth_en  = 1'b0;

  fragment_t     pending_frags[$];
  pixel_result_t expected_px[$];
  int unsigned   beats_taken = 0;
  int unsigned   pixels_seen = 0;
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  bit            offered = 1'b0;
  bit            draining = 1'b0;
  bit            steady;

  texel_modulate_alpha_blend dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_texel_argb(in_texel_argb), .in_dest_rgb(in_dest_rgb),
    .in_frag_depth(in_frag_depth), .in_stored_depth(in_stored_depth),
    .out_valid(out_valid), .out_rgb(out_rgb), .out_written(out_written),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned factor_limit(input logic [FACTOR_W-1:0] v);
    return 32'((v > UNITY_FACTOR) ? UNITY_FACTOR : v);
  endfunction

  function automatic logic [CHAN_W-1:0] blend_chan(input int unsigned tex_c,
      input int unsigned alpha, input int unsigned factor, input int unsigned dst_c,
      input int unsigned inv_alpha);
    int unsigned sum;
    sum = ((((tex_c * alpha) >> 8) * factor) >> 8) + ((dst_c * inv_alpha) >> 8);
    return (sum > CHANNEL_MAX) ? CHANNEL_MAX : sum[CHAN_W-1:0];
  endfunction

  function automatic pixel_result_t shade_fragment(input fragment_t f);
    pixel_result_t px;
    int unsigned   a;
    int unsigned   alpha;
    int unsigned   inv_alpha;
    if (depth_en && ($signed(f.frag) < $signed(f.stored))) begin
      px.rgb = f.dest;
      px.written = 1'b0;
      return px;
    end
    a = 32'(f.texel[31:24]);
    alpha = a + (a >> 7);
    inv_alpha = UNITY_FACTOR - ((alpha * fac_alpha) >> 8);
    px.rgb[7:0]   = blend_chan(32'(f.texel[7:0]), alpha, fac_red,
                               32'(f.dest[7:0]), inv_alpha);
    px.rgb[15:8]  = blend_chan(32'(f.texel[15:8]), alpha, fac_green,
                               32'(f.dest[15:8]), inv_alpha);
    px.rgb[23:16] = blend_chan(32'(f.texel[23:16]), alpha, fac_blue,
                               32'(f.dest[23:16]), inv_alpha);
    px.written = 1'b1;
    return px;
  endfunction

  function automatic fragment_t random_fragment();
    fragment_t f;
    f.texel = $urandom;
    case ($urandom_range(0, 7))
      0: f.texel[31:24] = 8'h00;
      1: f.texel[31:24] = 8'hFF;
      2: f.texel[31:24] = 8'h80;
      3: f.texel[31:24] = 8'h7F;
      default: ;
    endcase
    f.dest = RGB_W'($urandom);
    f.frag = $urandom;
    case ($urandom_range(0, 3))
      0: f.stored = f.frag;
      1: f.stored = f.frag + DEPTH_W'($urandom_range(0, 4)) - DEPTH_W'(2);
      2: f.stored = $urandom;
      default: f.stored = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
    return f;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] pixel %0d: %s", $time, pixels_seen, msg);
    mismatches++;
  endtask

  task automatic push_frag(input logic [TEXEL_W-1:0] texel, input logic [RGB_W-1:0] dest,
      input logic [DEPTH_W-1:0] frag, input logic [DEPTH_W-1:0] stored);
    pending_frags.push_back(fragment_t'{texel, dest, frag, stored});
  endtask

  // Called at a falling edge; leaves cfg_valid high so writes can go back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FACTOR_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MUL_RED:    fac_red = factor_limit(val);
      REG_MUL_GREEN:  fac_green = factor_limit(val);
      REG_MUL_BLUE:   fac_blue = factor_limit(val);
      REG_MUL_ALPHA:  fac_alpha = factor_limit(val);
      REG_DEPTH_TEST: depth_en = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [FACTOR_W-1:0] r, input logic [FACTOR_W-1:0] g,
      input logic [FACTOR_W-1:0] b, input logic [FACTOR_W-1:0] a,
      input logic [FACTOR_W-1:0] depth);
    write_reg(REG_MUL_RED, r);
    write_reg(REG_MUL_GREEN, g);
    write_reg(REG_MUL_BLUE, b);
    write_reg(REG_MUL_ALPHA, a);
    write_reg(REG_DEPTH_TEST, depth);
    // Unmapped indexes must leave every register alone.
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_DEPTH_TEST) + 1, LAST_CFG_INDEX)),
              FACTOR_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pending_frags.size() != 0 || expected_px.size() != 0);
  endtask

  function automatic logic [FACTOR_W-1:0] pick_factor();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return UNITY_FACTOR;
      2: return FACTOR_W'($urandom_range(257, 511));
      default: return FACTOR_W'($urandom_range(0, 256));
    endcase
  endfunction

  // Driver: offers the head of the pending queue and holds it until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!offered) begin
      if (draining && expected_px.size() == 0) draining = 1'b0;
      if (!draining && pending_frags.size() != 0 && $urandom_range(0, 199) == 0)
        draining = 1'b1;
      steady = beats_taken >= STEADY_FIRST && beats_taken < STEADY_LAST;
      if (pending_frags.size() != 0 && !draining &&
          (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        in_texel_argb <= pending_frags[0].texel;
        in_dest_rgb <= pending_frags[0].dest;
        in_frag_depth <= pending_frags[0].frag;
        in_stored_depth <= pending_frags[0].stored;
        start <= 1'b1;
        offered = 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each strobed pixel against the oldest prediction, then
  // records the beat taken at this edge.
  always @(posedge clk) begin
    pixel_result_t want;
    fragment_t     taken;
    if (rst_n && out_valid) begin
      if (expected_px.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding, rgb %h written %b",
                                  out_rgb, out_written));
      end else begin
        want = expected_px.pop_front();
        if (out_rgb !== want.rgb)
          report_mismatch($sformatf("out_rgb %h, predicted %h", out_rgb, want.rgb));
        if (out_written !== want.written)
          report_mismatch($sformatf("out_written %b, predicted %b", out_written,
                                    want.written));
      end
      pixels_seen++;
    end
    if (rst_n && start && !busy) begin
      taken = pending_frags.pop_front();
      expected_px.push_back(shade_fragment(taken));
      offered = 1'b0;
      beats_taken++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: unity factors, depth test off.
    push_frag(32'h0000_0000, 24'h000000, 32'h0000_0000, 32'h0000_0000);
    push_frag(32'hFFFF_FFFF, 24'hFFFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_frag(32'h00FF_FFFF, 24'h123456, 32'h0001_0000, 32'h0002_0000);
    push_frag(32'h7F80_8080, 24'hC0C0C0, 32'h0000_0000, 32'h0000_0000);
    push_frag(32'h80FF_00FF, 24'h00FF00, 32'h0000_0000, 32'h0000_0000);
    push_frag(32'hFF00_0000, 24'hFFFFFF, 32'h0000_0000, 32'h0000_0000);
    push_frag(32'h40A0_B0C0, 24'h5A5A5A, 32'h7FFF_FFFF, 32'h8000_0000);
    wait_idle();

    // All factors zero with the depth test on: passing fragments keep the destination.
    set_config('0, '0, '0, '0, 9'd1);
    @(posedge clk);
    push_frag(32'hFFFF_FFFF, 24'hA5C3E1, 32'h0001_0000, 32'h0001_0000);
    push_frag(32'hFFFF_FFFF, 24'h3C5A78, 32'h0000_0000, 32'h0000_0001);
    push_frag(32'h8012_3456, 24'hFFFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_frag(32'h8012_3456, 24'h000000, 32'h7FFF_FFFF, 32'h8000_0000);
    push_frag(32'hFF77_8899, 24'h102030, 32'hFFFF_FFFF, 32'h0000_0000);
    push_frag(32'hFF77_8899, 24'h405060, 32'h0000_0000, 32'hFFFF_FFFF);
    wait_idle();

    // Factors written above unity (clamped to unity) and zero alpha modulation: channels saturate.
    set_config(9'd257, 9'd511, UNITY_FACTOR, '0, 9'h1FE);
    @(posedge clk);
    push_frag(32'hFFFF_FFFF, 24'hFFFFFF, 32'h0000_0000, 32'h0000_0000);
    push_frag(32'h80FF_FFFF, 24'h808080, 32'h0000_0000, 32'h0000_0000);
    push_frag(32'hFF00_00FF, 24'h00FF00, 32'h8000_0000, 32'h0000_0000);
    push_frag(32'h00FF_FFFF, 24'h000000, 32'h0000_0000, 32'h0000_0000);
    wait_idle();

    set_config('0, 9'd128, UNITY_FACTOR, 9'd511, 9'd1);
    @(posedge clk);
    push_frag(32'hFF80_8080, 24'h404040, 32'h0000_0001, 32'h0000_0000);
    push_frag(32'h8011_2233, 24'hFFFFFF, 32'h0000_0005, 32'h0000_0005);
    push_frag(32'hFFFF_FFFF, 24'h000000, 32'hFFFF_FFFB, 32'h0000_0005);
    wait_idle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_config(pick_factor(), pick_factor(), pick_factor(), pick_factor(),
                 FACTOR_W'($urandom));
      @(posedge clk);
      for (int n = 0; n < PHASE_BEATS; n++) pending_frags.push_back(random_fragment());
      wait_idle();
    end

    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
